@@ design/kbps_pkg.sv @@
// kbps_pkg: shared types and constants for the KMP byte pattern search.
// No dependencies; imported by every module of the block but kbps_ram.
`timescale 1ns / 1ps

package kbps_pkg;

    localparam int PATTERN_BYTES     = 16;
    localparam int MAX_PATTERN_DEF   = 16;
    localparam int POSITION_BITS_DEF = 32;
    localparam int RESULT_POS_W      = 32;
    localparam int LENGTH_W          = 5;
    localparam int CFG_INDEX_W       = 2;
    localparam int CFG_DATA_W        = 64;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN  = 2'd2;

    typedef struct packed {
        logic [7:0] buffer_byte;
        logic       end_of_buffer;
    } in_word_t;

    typedef struct packed {
        logic                    found;
        logic [RESULT_POS_W-1:0] match_position;
    } out_word_t;

    // pattern registers as seen by the search controller
    typedef struct packed {
        logic [PATTERN_BYTES-1:0][7:0] bytes;
        logic [LENGTH_W-1:0]           length;
        logic                          written;
    } pat_cfg_t;

endpackage

@@ design/kbps_ram.sv @@
// kbps_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
`timescale 1ns / 1ps

module kbps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/kbps_cfg.sv @@
// kbps_cfg: pattern and length registers behind the configuration channel.
// Depends on kbps_pkg.
`timescale 1ns / 1ps

module kbps_cfg
    import kbps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output pat_cfg_t               pat
);

    logic [CFG_DATA_W-1:0] low_reg, low_next;
    logic [CFG_DATA_W-1:0] high_reg, high_next;
    logic [LENGTH_W-1:0]   len_reg, len_next;
    logic                  known;

    always_comb
    begin
        low_next  = low_reg;
        high_next = high_reg;
        len_next  = len_reg;
        known     = 1'b0;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PATTERN_LOW:
                begin
                    low_next = cfg_data;
                    known    = 1'b1;
                end
                REG_PATTERN_HIGH:
                begin
                    high_next = cfg_data;
                    known     = 1'b1;
                end
                REG_PATTERN_LEN:
                begin
                    len_next = cfg_data[LENGTH_W-1:0];
                    known    = 1'b1;
                end
                default:
                begin
                    known = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= '0;
            high_reg <= '0;
            len_reg  <= LENGTH_W'(1);
        end
        else
        begin
            low_reg  <= low_next;
            high_reg <= high_next;
            len_reg  <= len_next;
        end
    end

    // byte 0 sits in bits 7..0 of the low register
    assign pat.bytes   = {high_reg, low_reg};
    assign pat.length  = len_reg;
    assign pat.written = known;

endmodule

@@ design/kbps_ctrl.sv @@
// kbps_ctrl: border table build and KMP search sequencer around the table RAM.
// Depends on kbps_pkg and kbps_ram.
`timescale 1ns / 1ps

module kbps_ctrl
    import kbps_pkg::*;
#(
    parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  pat_cfg_t  pat,
    output logic      cfg_ready,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    localparam int CntW  = $clog2(MAX_PATTERN + 1);
    localparam int Depth = MAX_PATTERN + 1;
    localparam int ExtW  = (POSITION_BITS > RESULT_POS_W) ? POSITION_BITS : RESULT_POS_W;

    localparam logic [2:0] S_BINIT = 3'd0;
    localparam logic [2:0] S_BUILD = 3'd1;
    localparam logic [2:0] S_BWAIT = 3'd2;
    localparam logic [2:0] S_IDLE  = 3'd3;
    localparam logic [2:0] S_WALK  = 3'd4;
    localparam logic [2:0] S_SWAIT = 3'd5;

    logic [2:0]               state_reg, state_next;
    logic [CntW-1:0]          bi_reg, bi_next;
    logic [CntW-1:0]          bk_reg, bk_next;
    logic [CntW-1:0]          m_reg, m_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                     found_reg, found_next;
    logic [7:0]               byte_reg, byte_next;
    logic                     last_reg, last_next;
    logic                     out_valid_reg, out_valid_next;
    out_word_t                out_data_reg, out_data_next;

    logic                     wr_en;
    logic [CntW-1:0]          wr_addr;
    logic [CntW-1:0]          wr_data;
    logic                     rd_en;
    logic [CntW-1:0]          rd_addr;
    logic [CntW-1:0]          rd_data;

    logic [CntW-1:0]          eff_len;
    logic [CntW-1:0]          m_eff;
    logic [CntW-1:0]          m_inc;
    logic [CntW-1:0]          k_inc;
    logic [7:0]               pm, pk, pi;
    logic                     slot_free;
    logic [POSITION_BITS-1:0] pos_plus;
    logic [POSITION_BITS-1:0] pos_start;
    logic [ExtW-1:0]          ext_plus;
    logic [ExtW-1:0]          ext_start;

    // bytes past the register file read as zero
    function automatic logic [7:0] pat_byte(
        input logic [PATTERN_BYTES-1:0][7:0] bytes,
        input logic [CntW-1:0]               idx
    );
        logic [7:0] b;
        b = 8'h00;
        if (32'(idx) < PATTERN_BYTES)
        begin
            b = bytes[4'(idx)];
        end
        return b;
    endfunction

    kbps_ram #(
        .WIDTH (CntW),
        .DEPTH (Depth)
    ) u_border (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // length zero counts as one, clamp to the table size
    always_comb
    begin
        if (pat.length == '0)
        begin
            eff_len = CntW'(1);
        end
        else if (32'(pat.length) > MAX_PATTERN)
        begin
            eff_len = CntW'(MAX_PATTERN);
        end
        else
        begin
            eff_len = CntW'(pat.length);
        end
    end

    assign m_eff     = (m_reg >= eff_len) ? '0 : m_reg;
    assign pm        = pat_byte(pat.bytes, m_eff);
    assign pk        = pat_byte(pat.bytes, bk_reg);
    assign pi        = pat_byte(pat.bytes, bi_reg);
    assign m_inc     = m_eff + CntW'(1);
    assign k_inc     = bk_reg + CntW'(pk == pi);
    assign slot_free = !out_valid_reg || out_ready;
    assign pos_plus  = pos_reg + POSITION_BITS'(1);
    assign pos_start = pos_plus - POSITION_BITS'(eff_len);
    assign ext_plus  = ExtW'(pos_plus);
    assign ext_start = ExtW'(pos_start);

    always_comb
    begin
        state_next     = state_reg;
        bi_next        = bi_reg;
        bk_next        = bk_reg;
        m_next         = m_reg;
        pos_next       = pos_reg;
        found_next     = found_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;

        case (state_reg)
            S_BINIT:
            begin
                wr_en   = 1'b1;
                wr_addr = CntW'(1);
                wr_data = '0;
                bi_next = CntW'(1);
                bk_next = '0;
                m_next  = m_eff;
                state_next = S_BUILD;
            end
            S_BUILD:
            begin
                if (bi_reg >= eff_len)
                begin
                    state_next = S_IDLE;
                end
                else if (bk_reg != '0 && pk != pi)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = bk_reg;
                    state_next = S_BWAIT;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = bi_reg + CntW'(1);
                    wr_data = k_inc;
                    bk_next = k_inc;
                    bi_next = bi_reg + CntW'(1);
                end
            end
            S_BWAIT:
            begin
                bk_next    = rd_data;
                state_next = S_BUILD;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next  = in_data.buffer_byte;
                    last_next  = in_data.end_of_buffer;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (found_reg)
                begin
                    // tail after a match: count, clear on the last byte
                    if (last_reg)
                    begin
                        m_next     = '0;
                        pos_next   = '0;
                        found_next = 1'b0;
                    end
                    else
                    begin
                        pos_next = pos_plus;
                    end
                    state_next = S_IDLE;
                end
                else if (m_eff != '0 && pm != byte_reg)
                begin
                    // follow the failure link
                    rd_en      = 1'b1;
                    rd_addr    = m_eff;
                    m_next     = m_eff;
                    state_next = S_SWAIT;
                end
                else if (pm == byte_reg && m_inc == eff_len)
                begin
                    if (slot_free)
                    begin
                        out_valid_next               = 1'b1;
                        out_data_next.found          = 1'b1;
                        out_data_next.match_position = ext_start[RESULT_POS_W-1:0];
                        m_next     = '0;
                        if (last_reg)
                        begin
                            pos_next   = '0;
                            found_next = 1'b0;
                        end
                        else
                        begin
                            pos_next   = pos_plus;
                            found_next = 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                end
                else if (last_reg)
                begin
                    if (slot_free)
                    begin
                        out_valid_next               = 1'b1;
                        out_data_next.found          = 1'b0;
                        out_data_next.match_position = ext_plus[RESULT_POS_W-1:0];
                        m_next     = '0;
                        pos_next   = '0;
                        found_next = 1'b0;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    m_next     = (pm == byte_reg) ? m_inc : m_eff;
                    pos_next   = pos_plus;
                    state_next = S_IDLE;
                end
            end
            S_SWAIT:
            begin
                m_next     = rd_data;
                state_next = S_WALK;
            end
            default:
            begin
                state_next = S_BINIT;
            end
        endcase

        // any register write restarts the table build
        if (pat.written)
        begin
            state_next = S_BINIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_BINIT;
            bi_reg        <= '0;
            bk_reg        <= '0;
            m_reg         <= '0;
            pos_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bi_reg        <= bi_next;
            bk_reg        <= bk_next;
            m_reg         <= m_next;
            pos_reg       <= pos_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
    end

    assign in_ready  = (state_reg == S_IDLE) && !pat.written;
    assign cfg_ready = (state_reg != S_WALK) && (state_reg != S_SWAIT);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ design/kmp_byte_pattern_search.sv @@
// kmp_byte_pattern_search: top level, first-occurrence byte pattern search.
// Depends on kbps_pkg, kbps_cfg, kbps_ctrl (and kbps_ram below it).
`timescale 1ns / 1ps

// Usage
//   cfg channel : cfg_valid/cfg_ready with cfg_index and 64-bit cfg_data.
//                 Index 0 = pattern bytes 0..7, 1 = bytes 8..15, 2 = length.
//                 Other indexes are taken and ignored. Each write to 0, 1 or 2
//                 rebuilds the border table; write only between words.
//   in channel  : one buffer byte per word, end_of_buffer on the last one.
//   out channel : at most one word per buffer: found = 1 with the start
//                 index of the first match, or found = 0 with the buffer
//                 length when the last byte passes unmatched.
// Byte handling
//   A byte is accepted, then compared; each failure link followed adds a
//   table read and a wait state, as the links live in a table RAM with one
//   registered read port. Links followed are amortised below one per byte.
//   The next byte is taken only once the last one is through.
// Reset and rebuild
//   After reset or a register write in_ready stays low while the table is
//   built. Reset loads length 1 and an all-zero pattern.
// Stall
//   The result sits in an output register; the next byte is accepted while
//   it waits. A further result waits in the controller until the register
//   frees.

module kmp_byte_pattern_search
    import kbps_pkg::*;
#(
    parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_word_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_word_t              out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    pat_cfg_t pat;

    // pattern and length registers
    kbps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pat       (pat)
    );

    // table build, search walk and result register
    kbps_ctrl #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pat       (pat),
        .cfg_ready (cfg_ready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ design/kbps_checker.sv @@
// kbps_checker: port-level assertions for kmp_byte_pattern_search, with bind.
// Depends on kbps_pkg.
`timescale 1ns / 1ps

module kbps_checker
    import kbps_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input out_word_t              out_data,
    input logic                   cfg_valid,
    input logic                   cfg_ready,
    input logic [CFG_INDEX_W-1:0] cfg_index
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed under stall");

    // one byte in flight at a time
    a_one_byte: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("byte accepted while previous one in flight");

    // a register write triggers a table rebuild
    a_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && (cfg_index == REG_PATTERN_LOW
            || cfg_index == REG_PATTERN_HIGH || cfg_index == REG_PATTERN_LEN)
        |=> !in_ready)
        else $error("input open during table rebuild");

    // a new result comes only out of a byte being worked on
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result produced while idle");

endmodule

bind kmp_byte_pattern_search kbps_checker u_kbps_checker (.*);

@@ tb/sv/kbps_search_checker.sv @@
// kbps_search_checker: watches the config, byte and result channels of the
// KMP pattern search, keeps its own copy of the search state and checks each result word.
// Depends on kbps_pkg for the word types and register indexes.
`timescale 1ns / 1ps

module kbps_search_checker
    import kbps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  in_word_t               in_data,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  out_word_t              out_data,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatch_count,
    output int                     results_waiting
);

    // mirrored registers
    logic [63:0] pat_low;
    logic [63:0] pat_high;
    logic [4:0]  pat_len_reg;

    // mirrored search state
    logic [4:0]  borders [0:16];
    logic [4:0]  matched;
    logic [31:0] position;
    logic        done_flag;

    out_word_t   expected_words [$];
    out_word_t   head;
    int          errors;

    function automatic int unsigned active_len();
        int unsigned len;
        len = pat_len_reg;
        if (len == 0) len = 1;
        if (len > 16) len = 16;
        return len;
    endfunction

    function automatic logic [7:0] pattern_byte(input int unsigned i);
        if (i < 8) return pat_low[8*i +: 8];
        if (i < 16) return pat_high[8*(i-8) +: 8];
        return 8'h00;
    endfunction

    function automatic void rebuild_borders();
        int unsigned len;
        logic [4:0]  k;
        len = active_len();
        for (int i = 0; i <= 16; i++) borders[i] = '0;
        for (int unsigned i = 1; i < len; i++)
        begin
            k = borders[i];
            while (k > 0 && pattern_byte(k) != pattern_byte(i)) k = borders[k];
            if (pattern_byte(k) == pattern_byte(i)) k++;
            borders[i+1] = k;
        end
    endfunction

    function automatic void clear_search();
        matched   = '0;
        position  = '0;
        done_flag = 1'b0;
    endfunction

    function automatic void apply_write(input logic [CFG_INDEX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_PATTERN_LOW:  pat_low = value;
            REG_PATTERN_HIGH: pat_high = value;
            REG_PATTERN_LEN:  pat_len_reg = value[4:0];
            default:          return;
        endcase
        rebuild_borders();
        if (matched >= active_len()) matched = '0;
    endfunction

    // one byte through the search; pushes the result word it causes, if any
    function automatic void search_byte(input in_word_t w);
        int unsigned len;
        logic [31:0] at;
        out_word_t   r;
        len = active_len();
        at  = position;
        if (done_flag)
        begin
            // tail after a match: swallowed until the last byte
            if (w.end_of_buffer) clear_search();
            else position = at + 1;
        end
        else
        begin
            if (matched >= len) matched = '0;
            while (matched > 0 && pattern_byte(matched) != w.buffer_byte)
                matched = borders[matched];
            if (pattern_byte(matched) == w.buffer_byte) matched++;
            if (matched == len)
            begin
                r.found          = 1'b1;
                r.match_position = at + 1 - len;
                expected_words.push_back(r);
                if (w.end_of_buffer)
                    clear_search();
                else
                begin
                    done_flag = 1'b1;
                    matched   = '0;
                    position  = at + 1;
                end
            end
            else if (w.end_of_buffer)
            begin
                r.found          = 1'b0;
                r.match_position = at + 1;
                expected_words.push_back(r);
                clear_search();
            end
            else
                position = at + 1;
        end
    endfunction

    function automatic void report(input string what, input out_word_t exp_w,
                                   input out_word_t act_w);
        if (errors < 10)
            $display("%0t: %s: expected found=%0d pos=%0d, got found=%0d pos=%0d",
                     $realtime, what, exp_w.found, exp_w.match_position,
                     act_w.found, act_w.match_position);
        errors++;
    endfunction

    // results first: a word leaving at this edge belongs to an older byte
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low     = '0;
            pat_high    = '0;
            pat_len_reg = 5'd1;
            clear_search();
            rebuild_borders();
            expected_words.delete();
            errors = 0;
            mismatch_count  <= 0;
            results_waiting <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                    report("result word with none expected", '0, out_data);
                else
                begin
                    head = expected_words.pop_front();
                    if (head.found !== out_data.found)
                        report("found differs", head, out_data);
                    else if (head.match_position !== out_data.match_position)
                        report("match_position differs", head, out_data);
                end
            end
            if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
            if (in_valid && in_ready) search_byte(in_data);
            mismatch_count  <= errors;
            results_waiting <= expected_words.size();
        end
    end

endmodule

@@ tb/sv/tb_kmp_byte_pattern_search.sv @@
// tb_kmp_byte_pattern_search: stimulus and verdict for the KMP byte pattern search.
// Depends on kbps_pkg, kmp_byte_pattern_search and kbps_search_checker.
`timescale 1ns / 1ps

module tb_kmp_byte_pattern_search;
    import kbps_pkg::*;

    // index the block takes and throws away
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    // drain allowance for the slowest byte, which follows up to 15 failure links
    localparam int DRAIN_CYCLES = 48;
    localparam int WORD_TARGET  = 1500;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    in_word_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_word_t              out_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int  mismatch_total;
    int  results_outstanding;
    bit  steady_run = 1'b0;   // no idling on either side while set
    int  words_sent = 0;

    // stimulus-side view of the programmed pattern, used to build buffers
    logic [7:0]  pat_bytes [0:15];
    int unsigned pat_len_eff = 1;
    logic [7:0]  alphabet [0:2];
    int unsigned alpha_n = 1;
    logic [7:0]  search_buf [0:63];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    kmp_byte_pattern_search DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    kbps_search_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_total),
        .results_waiting (results_outstanding)
    );

    // receiver back-pressure: roughly 27 stalled cycles in a hundred
    always @(posedge clk)
        out_ready <= steady_run || ($urandom_range(99) >= 27);

    // Offer one byte and hold it until taken. Valid is only dropped for an
    // idle gap, never lowered and raised in the same step.
    task automatic send_word(input logic [7:0] b, input logic eob);
        in_word_t w;
        w.buffer_byte   = b;
        w.end_of_buffer = eob;
        if (!steady_run && $urandom_range(99) < 27)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
    endtask

    // Register write; cfg_valid stays up for back-to-back writes and is
    // lowered by the caller once the series is done.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Quiet the byte channel, let every expected word arrive, then allow
    // for bytes still in the block that cause no word (tail after a match).
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [63:0] pack_half(input int unsigned base);
        logic [63:0] v;
        for (int i = 0; i < 8; i++) v[8*i +: 8] = pat_bytes[base + i];
        return v;
    endfunction

    // New pattern: small alphabet so that borders and failure links are
    // common, now and then fully random bytes. Each register is written
    // with good odds, in a rotating order.
    task automatic program_pattern();
        int unsigned first;
        int unsigned sel;
        int unsigned len_code;
        bit          wild;
        logic [63:0] len_word;
        alpha_n = $urandom_range(3, 1);
        for (int i = 0; i < 3; i++) alphabet[i] = 8'($urandom_range(255));
        wild  = ($urandom_range(7) == 0);
        first = $urandom_range(2);
        for (int j = 0; j < 3; j++)
        begin
            sel = (first + j) % 3;
            if ($urandom_range(9) < 8)
            begin
                if (sel == 0 || sel == 1)
                begin
                    for (int i = 0; i < 8; i++)
                        pat_bytes[8*sel + i] = wild ? 8'($urandom_range(255))
                                                    : alphabet[$urandom_range(alpha_n-1)];
                    write_reg(sel == 0 ? REG_PATTERN_LOW : REG_PATTERN_HIGH,
                              pack_half(8*sel));
                end
                else
                begin
                    sel = $urandom_range(99);
                    if (sel < 60)      len_code = $urandom_range(6, 1);
                    else if (sel < 90) len_code = $urandom_range(16, 7);
                    else if (sel < 95) len_code = 0;
                    else               len_code = $urandom_range(31, 17);
                    len_word = $urandom_range(1) ? {$urandom, $urandom} : 64'd0;
                    len_word[4:0] = len_code[4:0];
                    write_reg(REG_PATTERN_LEN, len_word);
                    pat_len_eff = (len_code == 0) ? 1 : (len_code > 16 ? 16 : len_code);
                end
            end
        end
        if ($urandom_range(9) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
        cfg_valid <= 1'b0;
    endtask

    // One buffer: mostly alphabet bytes with whole copies and prefixes of
    // the pattern spliced in, sometimes plain noise. An open buffer leaves
    // the search mid-way so the next register write lands inside it.
    task automatic send_buffer(input bit closed);
        int unsigned n;
        int unsigned fill;
        int unsigned take;
        int unsigned pick;
        bit          noise;
        n     = ($urandom_range(9) == 0) ? $urandom_range(64, 25) : $urandom_range(24, 1);
        noise = ($urandom_range(6) == 0);
        fill  = 0;
        while (fill < n)
        begin
            pick = $urandom_range(9);
            if (noise || pick == 9)
            begin
                search_buf[fill] = 8'($urandom_range(255));
                fill++;
            end
            else if (pick < 5)
            begin
                // full copy for low picks, a random prefix otherwise
                take = (pick < 3) ? pat_len_eff : $urandom_range(pat_len_eff, 1);
                for (int i = 0; i < take && fill < n; i++)
                begin
                    search_buf[fill] = pat_bytes[i];
                    fill++;
                end
            end
            else
            begin
                search_buf[fill] = alphabet[$urandom_range(alpha_n-1)];
                fill++;
            end
        end
        steady_run <= (words_sent >= 700 && words_sent < 1000);
        for (int i = 0; i < n; i++)
            send_word(search_buf[i], closed && (i == n - 1));
    endtask

    initial
    begin
        int unsigned nbuf;
        for (int i = 0; i < 16; i++) pat_bytes[i] = 8'h00;
        alphabet[0] = 8'h00;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset pattern is a single zero byte: match lands on the last byte
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b1);
        settle();

        // length 0 reads as 1; byte FF matches mid-buffer, tail swallowed;
        // unknown index must change nothing
        write_reg(REG_PATTERN_LOW, {$urandom, $urandom} | 64'hFF);
        write_reg(REG_PATTERN_LEN, 64'd0);
        write_reg(REG_UNUSED, 64'd5);
        cfg_valid <= 1'b0;
        send_word(8'h12, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h34, 1'b1);
        settle();

        // "aab" against "aaab": needs a failure link to find index 1
        write_reg(REG_PATTERN_LOW, 64'h0000_0000_0062_6161);
        write_reg(REG_PATTERN_LEN, 64'd3);
        cfg_valid <= 1'b0;
        send_word(8'h61, 1'b0);
        send_word(8'h61, 1'b0);
        send_word(8'h61, 1'b0);
        send_word(8'h62, 1'b1);
        // two bytes matched, then shrink the pattern to two bytes mid-buffer:
        // the partial match restarts and the buffer ends unmatched
        send_word(8'h61, 1'b0);
        send_word(8'h61, 1'b0);
        settle();
        write_reg(REG_PATTERN_LEN, 64'd2);
        cfg_valid <= 1'b0;
        send_word(8'h61, 1'b1);
        settle();

        // oversized length clamps to 16; full-width pattern found on last byte
        for (int i = 0; i < 16; i++)
            pat_bytes[i] = (i == 0) ? 8'h00 : (i == 15 ? 8'hFF : 8'($urandom_range(255)));
        write_reg(REG_PATTERN_LOW, pack_half(0));
        write_reg(REG_PATTERN_HIGH, pack_half(8));
        write_reg(REG_PATTERN_LEN, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_valid <= 1'b0;
        pat_len_eff = 16;
        for (int i = 0; i < 16; i++) send_word(pat_bytes[i], i == 15);

        // random phases: new pattern when idle, then a few buffers
        while (words_sent < WORD_TARGET)
        begin
            settle();
            program_pattern();
            nbuf = $urandom_range(4, 1);
            for (int b = 0; b < nbuf; b++)
                send_buffer(!(b == nbuf - 1 && $urandom_range(4) == 0));
        end

        settle();
        if (mismatch_total == 0 && results_outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #6_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
